FILE: rtl/core/ledgam_pkg.sv
// Package with the types, constants and gamma threshold table of the LED ring gamma encoder.
`default_nettype none

package ledgam_pkg;

  localparam int IDX_W   = 5;
  localparam int LIN_W   = 17;
  localparam int CODE_W  = 8;
  localparam int FRAME_W = 32;
  localparam int FRAC_W  = 16;
  localparam int BIG_W   = 192;

  localparam logic [LIN_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [IDX_W:0]   RING_SIZE = 6'd24;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [LIN_W-1:0]   lin_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [FRAC_W-1:0]  frac_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS    = 2'd0,
    REG_RING_OFFSET   = 2'd1,
    REG_RING_REVERSED = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } pipe_ctl_t;

  typedef logic [255:0][LIN_W-1:0] thr_table_t;

  // True when v^5 * 510^11 >= (2c-1)^11 * 65536^5, evaluated exactly.
  function automatic logic thr_reaches(input lin_t v, input int c);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    lhs = BIG_W'(1);
    rhs = BIG_W'(1);
    for (int n = 0; n < 5; n++) begin
      lhs = lhs * BIG_W'(v);
      rhs = rhs << FRAC_W;
    end
    for (int n = 0; n < 11; n++) begin
      lhs = lhs * BIG_W'(510);
      rhs = rhs * BIG_W'(2 * c - 1);
    end
    return lhs >= rhs;
  endfunction

  function automatic thr_table_t build_thr();
    thr_table_t t;
    lin_t       lo;
    lin_t       hi;
    lin_t       mid;
    t = '0;
    for (int c = 1; c <= 255; c++) begin
      lo = 17'd1;
      hi = ONE_Q16;
      for (int s = 0; s < 18; s++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (thr_reaches(mid, c)) begin
            hi = mid;
          end else begin
            lo = mid + 17'd1;
          end
        end
      end
      t[c] = lo;
    end
    return t;
  endfunction

  // Entry c is the least scaled value that encodes to c or more; entry zero is unused.
  localparam thr_table_t GAMMA_THR = build_thr();

endpackage

`default_nettype wire

FILE: rtl/core/ledgam_channel.sv
// One color channel: brightness multiply, then gamma encoding by a search of the threshold table.
`default_nettype none

module ledgam_channel (
  input  wire logic                  clk,
  input  wire ledgam_pkg::pipe_ctl_t ctl,
  input  wire ledgam_pkg::lin_t      lin,
  input  wire ledgam_pkg::lin_t      scale,
  output ledgam_pkg::code_t          code
);
  import ledgam_pkg::*;

  logic [2*LIN_W-1:0] product;
  logic               sat_nxt;
  logic               sat_r;
  frac_t              frac_nxt;
  frac_t              frac_r;
  code_t              code_nxt;
  code_t              code_r;
  code_t              cand;

  always_comb begin
    product  = lin * scale;
    sat_nxt  = |product[2*LIN_W-1:LIN_W-1+FRAC_W];
    frac_nxt = product[FRAC_W+FRAC_W-1:FRAC_W];
  end

  // Finds the largest code whose threshold is reached, one bit per step from the top.
  always_comb begin
    code_nxt = '0;
    cand     = '0;
    if (sat_r) begin
      code_nxt = '1;
    end else begin
      for (int b = CODE_W - 1; b >= 0; b--) begin
        cand = code_nxt | (code_t'(1) << b);
        if (GAMMA_THR[cand] <= {1'b0, frac_r}) begin
          code_nxt = cand;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      sat_r  <= sat_nxt;
      frac_r <= frac_nxt;
    end
    if (ctl.s3_load) begin
      code_r <= code_nxt;
    end
  end

  assign code = code_r;

endmodule

`default_nettype wire

FILE: rtl/core/led_ring_pixel_gamma_encoder.sv
// Top level of the LED ring pixel gamma encoder.
// The block takes one RGBW pixel per clock cycle while in_tready is high and returns one encoded
// pixel per input transaction through a three-register pipeline: an input register, a register
// after the four brightness multipliers, and the output register after the gamma threshold
// search. Each stage moves on when the stage after it is empty or moving, so a free stage keeps
// accepting pixels while a finished result waits. Configuration writes are always ready and
// take effect at once; write them only while no pixel is in flight.
`default_nettype none

module led_ring_pixel_gamma_encoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // pixel_index[4:0], red_linear[21:5], green_linear[38:22], blue_linear[55:39],
  // white_linear[72:56], zero padding.
  input  wire logic [ledgam_pkg::IN_DATA_W-1:0] in_tdata,
  // scale_enable[0].
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // strip_pos[4:0], red_code[12:5], green_code[20:13], blue_code[28:21],
  // white_code[36:29], frames_shown[68:37], zero padding.
  output logic [ledgam_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ledgam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ledgam_pkg::LIN_W-1:0]     cfg_data
);
  import ledgam_pkg::*;

  lin_t       brightness_r;
  idx_t       ring_offset_r;
  logic       ring_reversed_r;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic       s2_valid_r;
  logic       s2_valid_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       s1_rdy;
  logic       s2_rdy;
  logic       s3_rdy;
  pipe_ctl_t  ctl;

  idx_t       s1_idx_r;
  lin_t       s1_lin_r [4];
  logic       s1_apply_r;

  lin_t       scale;
  idx_t       offset_mod;
  idx_t       index_mod;
  logic [IDX_W:0] pos_sum;
  idx_t       phys_nxt;
  logic       frame_end;
  frame_t     frame_cnt_r;
  frame_t     frame_cnt_nxt;

  idx_t       s2_phys_r;
  frame_t     s2_frames_r;
  idx_t       s3_phys_r;
  frame_t     s3_frames_r;
  code_t      codes [4];

  // Configuration.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r    <= 17'd32768;
      ring_offset_r   <= '0;
      ring_reversed_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_e'(cfg_index))
        REG_BRIGHTNESS:    brightness_r    <= cfg_data;
        REG_RING_OFFSET:   ring_offset_r   <= cfg_data[IDX_W-1:0];
        REG_RING_REVERSED: ring_reversed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  always_comb begin
    s3_rdy        = !out_valid_r || out_tready;
    s2_rdy        = !s2_valid_r || s3_rdy;
    s1_rdy        = !s1_valid_r || s2_rdy;
    s1_valid_nxt  = s1_rdy ? in_tvalid : s1_valid_r;
    s2_valid_nxt  = s2_rdy ? s1_valid_r : s2_valid_r;
    out_valid_nxt = s3_rdy ? s2_valid_r : out_valid_r;
    ctl.s2_load   = s1_valid_r && s2_rdy;
    ctl.s3_load   = s2_valid_r && s3_rdy;
  end

  assign in_tready  = s1_rdy;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      frame_cnt_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_tvalid && s1_rdy) begin
      s1_idx_r    <= in_tdata[4:0];
      s1_lin_r[0] <= in_tdata[21:5];
      s1_lin_r[1] <= in_tdata[38:22];
      s1_lin_r[2] <= in_tdata[55:39];
      s1_lin_r[3] <= in_tdata[72:56];
      s1_apply_r  <= in_tuser;
    end
  end

  // Scale factor, ring position and frame count.
  always_comb begin
    if (s1_apply_r) begin
      scale = (brightness_r > ONE_Q16) ? ONE_Q16 : brightness_r;
    end else begin
      scale = ONE_Q16;
    end

    offset_mod = ({1'b0, ring_offset_r} >= RING_SIZE) ?
                 IDX_W'({1'b0, ring_offset_r} - RING_SIZE) : ring_offset_r;
    index_mod  = ({1'b0, s1_idx_r} >= RING_SIZE) ?
                 IDX_W'({1'b0, s1_idx_r} - RING_SIZE) : s1_idx_r;

    if (ring_reversed_r) begin
      pos_sum = {1'b0, offset_mod} + RING_SIZE - {1'b0, index_mod};
    end else begin
      pos_sum = {1'b0, offset_mod} + {1'b0, index_mod};
    end
    phys_nxt = (pos_sum >= RING_SIZE) ? IDX_W'(pos_sum - RING_SIZE) : pos_sum[IDX_W-1:0];

    frame_end     = ({1'b0, s1_idx_r} == RING_SIZE - 6'd1);
    frame_cnt_nxt = (ctl.s2_load && frame_end) ? frame_cnt_r + 32'd1 : frame_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      s2_phys_r   <= phys_nxt;
      s2_frames_r <= frame_cnt_nxt;
    end
    if (ctl.s3_load) begin
      s3_phys_r   <= s2_phys_r;
      s3_frames_r <= s2_frames_r;
    end
  end

  for (genvar ch = 0; ch < 4; ch++) begin : g_chan
    ledgam_channel u_chan (
      .clk   (clk),
      .ctl   (ctl),
      .lin   (s1_lin_r[ch]),
      .scale (scale),
      .code  (codes[ch])
    );
  end

  assign out_tdata = {3'b000, s3_frames_r, codes[3], codes[2], codes[1], codes[0], s3_phys_r};

  a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (frame_cnt_r != $past(frame_cnt_r)) |->
      (frame_cnt_r == $past(frame_cnt_r) + 32'd1) && $past(ctl.s2_load))
    else $error("frame counter moved without a frame-end transaction");

  a_phys_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, s3_phys_r} < RING_SIZE))
    else $error("physical index outside the ring");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s2_valid_r && out_valid_r && !out_tready))
    else $error("input stalled while the pipeline has room");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s3_rdy) |=> s2_valid_r && $stable(s2_frames_r))
    else $error("stalled stage two transaction changed");

endmodule

`default_nettype wire
